/* rtl/frac_pkg.sv */
package frac_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int RES_W         = 32;
  localparam int CNT_W         = $clog2(PROD_W + 1);
  localparam int IN_DATA_W     = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W    = 2 * RES_W;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

  function automatic logic [RES_W-1:0] to_result(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W+RES_W-1:0] ext;
    ext = (SUM_W + RES_W)'(v);
    return ext[RES_W-1:0];
  endfunction

endpackage

/* rtl/fraction_arith_reduce.sv */
// Signed fraction arithmetic with gcd reduction.
// Input channel in_*: one word per operation. in_tuser carries the operation
// (add, subtract, multiply, divide); in_tdata carries left numerator, left
// denominator, right numerator, right denominator, lowest bits first.
// Result channel out_*: one word per input word. out_tdata holds the reduced
// numerator and denominator; out_tuser flags a zero unreduced denominator,
// in which case both values are zero. A zero numerator gives 0/1.
// One word is processed at a time; in_tready is high only while idle.
// Sequence: the products are formed in turn through one shared multiplier, a
// check state follows, then a binary gcd (one shift or subtract per cycle, up to
// about 4*PROD_W steps, plus start and finish), two restoring divisions, then
// the load of the output register.
// The gcd and divisions are skipped when the numerator or denominator is zero.
// The result is held in the output register until out_tready; the next word
// is taken meanwhile, and only the load of its result waits for the register.
// Synchronous reset returns the block to idle and drops any pending result.
module fraction_arith_reduce
  import frac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // left_num, left_den, right_num, right_den
  input  logic [1:0]            in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_numerator, result_denominator
  output logic                  out_tuser   // zero_denominator
);

  localparam int W = OPERAND_WIDTH;

  state_t state_r, state_nxt;

  op_t                        op_r, op_nxt;
  logic signed [W-1:0]        ln_r, ln_nxt;
  logic signed [W-1:0]        ld_r, ld_nxt;
  logic signed [W-1:0]        rn_r, rn_nxt;
  logic signed [W-1:0]        rd_r, rd_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [SUM_W-1:0]    n_r, n_nxt;
  logic signed [SUM_W-1:0]    d_r, d_nxt;
  logic [PROD_W-1:0]          qn_r, qn_nxt;
  logic [RES_W-1:0]           res_n_r, res_n_nxt;
  logic [RES_W-1:0]           res_d_r, res_d_nxt;
  logic                       zd_r, zd_nxt;
  logic                       out_vld_r, out_vld_nxt;

  logic signed [W-1:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [SUM_W-1:0]    prod_ext;
  logic [PROD_W-1:0]          mag_n, mag_d;
  logic signed [SUM_W-1:0]    qn_s, qd_s;

  logic                       gcd_start, gcd_done;
  logic [PROD_W-1:0]          gcd_g;
  logic                       div_start, div_done;
  logic [PROD_W-1:0]          div_dividend, div_q;

  always_comb begin
    mul_a = ld_r;
    mul_b = rd_r;
    case (cnt_r)
      2'd0: begin
        mul_a = ln_r;
        mul_b = (op_r == OP_MUL) ? rn_r : rd_r;
      end
      2'd1: begin
        mul_a = ld_r;
        mul_b = rn_r;
      end
      default: begin
        mul_a = ld_r;
        mul_b = (op_r == OP_DIV) ? rn_r : rd_r;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = SUM_W'(prod_r);

  assign mag_n = PROD_W'(n_r[SUM_W-1] ? -n_r : n_r);
  assign mag_d = PROD_W'(d_r[SUM_W-1] ? -d_r : d_r);

  assign qn_s = n_r[SUM_W-1] ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});
  assign qd_s = d_r[SUM_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  assign div_dividend = (state_r == ST_GCD) ? mag_n : mag_d;

  frac_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (mag_n),
    .b_in  (mag_d),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  frac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ln_nxt      = ln_r;
    ld_nxt      = ld_r;
    rn_nxt      = rn_r;
    rd_nxt      = rd_r;
    cnt_nxt     = cnt_r;
    prod_nxt    = prod_r;
    n_nxt       = n_r;
    d_nxt       = d_r;
    qn_nxt      = qn_r;
    res_n_nxt   = res_n_r;
    res_d_nxt   = res_d_r;
    zd_nxt      = zd_r;
    out_vld_nxt = out_vld_r && !out_tready;
    gcd_start   = 1'b0;
    div_start   = 1'b0;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          ln_nxt    = in_tdata[W-1:0];
          ld_nxt    = in_tdata[2*W-1:W];
          rn_nxt    = in_tdata[3*W-1:2*W];
          rd_nxt    = in_tdata[4*W-1:3*W];
          cnt_nxt   = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = mul_p;
        cnt_nxt  = cnt_r + 2'd1;
        case (cnt_r)
          2'd1: n_nxt = prod_ext;
          2'd2: begin
            if (op_r == OP_ADD) begin
              n_nxt = n_r + prod_ext;
            end else if (op_r == OP_SUB) begin
              n_nxt = n_r - prod_ext;
            end
          end
          2'd3: begin
            d_nxt     = prod_ext;
            state_nxt = ST_CHECK;
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        if (d_r == '0 || n_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          gcd_start = 1'b1;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          qn_nxt    = div_q;
          div_start = 1'b1;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          if (d_r == '0) begin
            res_n_nxt = '0;
            res_d_nxt = '0;
            zd_nxt    = 1'b1;
          end else if (n_r == '0) begin
            res_n_nxt = '0;
            res_d_nxt = RES_W'(1);
            zd_nxt    = 1'b0;
          end else begin
            res_n_nxt = to_result(qn_s);
            res_d_nxt = to_result(qd_s);
            zd_nxt    = 1'b0;
          end
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r    <= op_nxt;
    ln_r    <= ln_nxt;
    ld_r    <= ld_nxt;
    rn_r    <= rn_nxt;
    rd_r    <= rd_nxt;
    prod_r  <= prod_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    qn_r    <= qn_nxt;
    res_n_r <= res_n_nxt;
    res_d_r <= res_d_nxt;
    zd_r    <= zd_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_d_r, res_n_r};
  assign out_tuser  = zd_r;

endmodule

/* rtl/frac_gcd.sv */
module frac_gcd
  import frac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] a_in,
  input  logic [PROD_W-1:0] b_in,
  output logic              done,
  output logic [PROD_W-1:0] g
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] a_r, a_nxt;
  logic [PROD_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;

  // binary gcd, one compare/subtract or shift per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (a_r == b_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + CNT_W'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  assign done = done_r;
  assign g    = a_r << k_r;

endmodule

/* rtl/frac_div.sv */
module frac_div
  import frac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [PROD_W-1:0] divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W:0]   shifted;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    shifted  = {rem_r[PROD_W-1:0], q_r[PROD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(PROD_W);
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        q_nxt   = {q_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
